// File: sv/bra_pkg.sv
// Shared types, constants and helpers for the binary to radix ASCII converter.
package bra_pkg;

  localparam int VALUE_W   = 63;  // width of the input value port
  localparam int RADIX_W   = 6;   // width of the radix register
  localparam int DIGIT_W   = 6;   // width of one digit value (0..35)
  localparam int CHAR_W    = 7;   // width of one ASCII character
  localparam int STEP_BITS = 8;   // dividend bits retired per division cycle

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [DIGIT_W-1:0] DEC_LIMIT  = 6'd9;
  localparam logic [DIGIT_W-1:0] ALPHA_BASE = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h41;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new value and clear digit state
    logic step;       // run one division step
    logic last_step;  // final cycle of a digit: store the remainder
    logic rd_start;   // point the read pointer at the top digit
    logic rd_en;      // read one stored digit and move toward the bottom
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic q_zero;   // quotient register is zero
    logic rd_done;  // read pointer sits on the least significant digit
  } dp_sts_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d <= DEC_LIMIT) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - ALPHA_BASE);
    end
    return c;
  endfunction

endpackage

// File: sv/binary_to_radix_ascii.sv
// Top level of the binary to radix ASCII converter.
//
// Usage:
//   Input: raise start with in_value; the value transfers at the clock edge
//   where start is high and busy is low. Only the low VALUE_BITS bits count.
//   Radix: write cfg_radix with cfg_wr_en while busy is low; 0 and 1 act as
//   radix 2, values above 36 act as radix 36. Reset leaves radix 10.
//   Output: one ASCII character per out_valid strobe, most significant digit
//   first, out_last set on the final character. Each strobe lasts one cycle
//   and the receiver cannot hold it off; there is no back-pressure.
// Operation: each digit takes a division pass through the shared restoring
//   divider, eight dividend bits per cycle, and then a check of the quotient;
//   after the last digit the characters follow one per cycle from the digit
//   memory's single read port. busy drops on the cycle after the last read;
//   the final strobe overlaps the next item's start.
// Reset: synchronous, active low; clears the controller and strobes and
//   returns the radix to 10. The digit memory needs no clearing.
module binary_to_radix_ascii #(
  parameter int VALUE_BITS = 63
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [bra_pkg::VALUE_W-1:0]  in_value,
  input  logic                         cfg_wr_en,
  input  logic [bra_pkg::RADIX_W-1:0]  cfg_radix,
  output logic                         out_valid,
  output logic [bra_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                         out_last
);
  import bra_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence division passes and the reverse-order readout.
  bra_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Hold the radix, divide, store remainders and drive the character strobe.
  bra_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_radix      (cfg_radix),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

endmodule

// File: sv/bra_ctrl.sv
// Sequencing state machine: division passes, digit check and character readout.
module bra_ctrl #(
  parameter int VALUE_BITS = 63
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output bra_pkg::dp_cmd_t  cmd,
  input  bra_pkg::dp_sts_t  sts
);
  import bra_pkg::*;

  localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam logic [CW-1:0] LAST_CHUNK = CW'(CHUNKS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CHK,
    S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] step_cnt_r, step_cnt_nxt;
  logic          last_chunk;

  assign last_chunk = (step_cnt_r == LAST_CHUNK);
  assign busy       = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    step_cnt_nxt = step_cnt_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          step_cnt_nxt = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step      = 1'b1;
        cmd.last_step = last_chunk;
        if (last_chunk) begin
          state_nxt = S_CHK;
        end else begin
          step_cnt_nxt = step_cnt_r + 1'b1;
        end
      end
      S_CHK: begin
        if (sts.q_zero) begin
          cmd.rd_start = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          step_cnt_nxt = '0;
          state_nxt    = S_DIV;
        end
      end
      S_EMIT: begin
        cmd.rd_en = 1'b1;
        if (sts.rd_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

endmodule

// File: sv/bra_dp.sv
// Datapath: radix register, iterative divider, digit memory and output register.
module bra_dp #(
  parameter int VALUE_BITS = 63
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bra_pkg::VALUE_W-1:0]  in_value,
  input  logic                         cfg_wr_en,
  input  logic [bra_pkg::RADIX_W-1:0]  cfg_radix,
  input  bra_pkg::dp_cmd_t             cmd,
  output bra_pkg::dp_sts_t             sts,
  output logic                         out_valid,
  output logic [bra_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                         out_last
);
  import bra_pkg::*;

  localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int QW     = CHUNKS * STEP_BITS;
  localparam int DEPTH  = VALUE_BITS;
  localparam int IW     = $clog2(DEPTH);
  localparam int NW     = $clog2(DEPTH + 1);

  logic [RADIX_W-1:0]   cfg_radix_r;
  logic [RADIX_W-1:0]   rdx_r;
  logic [RADIX_W-1:0]   rdx_clamp;
  logic [QW-1:0]        q_r;
  logic [DIGIT_W-1:0]   rem_r;
  logic [NW-1:0]        ndig_r;
  logic [IW-1:0]        rd_ptr_r;
  logic [DIGIT_W-1:0]   rd_data_r;
  logic                 rd_vld_r;
  logic                 rd_last_r;
  logic [DIGIT_W-1:0]   mem [DEPTH];

  logic [DIGIT_W-1:0]   rem_nxt;
  logic [STEP_BITS-1:0] qbits;

  // Clamp the configured radix into the legal range.
  always_comb begin
    if (cfg_radix_r < RADIX_MIN) begin
      rdx_clamp = RADIX_MIN;
    end else if (cfg_radix_r > RADIX_MAX) begin
      rdx_clamp = RADIX_MAX;
    end else begin
      rdx_clamp = cfg_radix_r;
    end
  end

  // Restoring division over the top STEP_BITS bits of the quotient register.
  always_comb begin
    logic [DIGIT_W:0]   t;
    logic [DIGIT_W-1:0] r;
    r     = rem_r;
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, q_r[QW-1-i]};
      if (t >= {1'b0, rdx_r}) begin
        r                      = DIGIT_W'(t - {1'b0, rdx_r});
        qbits[STEP_BITS-1-i]   = 1'b1;
      end else begin
        r = DIGIT_W'(t);
      end
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_radix_r <= RADIX_RESET;
      rdx_r       <= RADIX_RESET;
      rem_r       <= '0;
      ndig_r      <= '0;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_radix_r <= cfg_radix;
      end
      if (cmd.load) begin
        rdx_r  <= rdx_clamp;
        rem_r  <= '0;
        ndig_r <= '0;
      end else if (cmd.step) begin
        rem_r <= cmd.last_step ? '0 : rem_nxt;
        if (cmd.last_step) begin
          ndig_r <= ndig_r + 1'b1;
        end
      end
      rd_vld_r  <= cmd.rd_en;
      rd_last_r <= cmd.rd_en && (rd_ptr_r == '0);
    end
  end

  // Quotient register and read pointer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r <= QW'(in_value[VALUE_BITS-1:0]);
    end else if (cmd.step) begin
      q_r <= QW'({q_r, qbits});
    end
    if (cmd.rd_start) begin
      rd_ptr_r <= IW'(ndig_r - 1'b1);
    end else if (cmd.rd_en) begin
      rd_ptr_r <= rd_ptr_r - 1'b1;
    end
  end

  // Digit memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.step && cmd.last_step) begin
      mem[ndig_r[IW-1:0]] <= rem_nxt;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign sts.q_zero  = (q_r == '0);
  assign sts.rd_done = (rd_ptr_r == '0);

  assign out_valid      = rd_vld_r;
  assign out_last       = rd_last_r;
  assign out_digit_char = digit_to_ascii(rd_data_r);

  a_rem_below_radix : assert property (@(posedge clk) disable iff (!rst_n)
    rem_r < rdx_r)
    else $error("partial remainder not below radix");

  a_digit_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    ndig_r <= NW'(DEPTH))
    else $error("digit count exceeds memory depth");

  a_last_ends_burst : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("character strobe follows the last character");

  a_load_clears_count : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (ndig_r == '0))
    else $error("digit count not cleared on load");

endmodule

// File: bench/tb_binary_to_radix_ascii.sv
// Self-checking bench for the binary to radix ASCII converter: random values, radixes and gaps.
module tb_binary_to_radix_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  import bra_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 9;
  localparam int MAX_REPORTS = 10;
  // Overall cycle limit for the whole run, used by the watchdog.
  localparam longint CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 46;
  localparam int QUIET_PHASE     = 5;   // phase run without any input gaps
  localparam int SETTLE_CYCLES   = 40;

  // One ASCII character as the block emits it.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  // Tracks the radix register, spells each accepted value into characters
  // and compares the strobed characters in order.
  class radix_spell_board;
    logic [RADIX_W-1:0] radix_reg;
    ascii_char_t        pending_chars[$];
    int                 failures;

    function new();
      radix_reg = RADIX_RESET;
      failures  = 0;
    endfunction

    function void set_radix(input logic [RADIX_W-1:0] r);
      radix_reg = r;
    endfunction

    function void flag(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // Spell one accepted value, most significant digit first.
    function void note_value(input logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] rest;
      logic [VALUE_W-1:0] base;
      logic [DIGIT_W-1:0] digits[$];
      logic [DIGIT_W-1:0] d;
      ascii_char_t        c;
      base = VALUE_W'(radix_reg);
      if (radix_reg < RADIX_MIN) base = VALUE_W'(RADIX_MIN);
      if (radix_reg > RADIX_MAX) base = VALUE_W'(RADIX_MAX);
      rest = v;
      do begin
        digits.push_front(DIGIT_W'(rest % base));
        rest = rest / base;
      end while (rest != '0);
      foreach (digits[i]) begin
        d = digits[i];
        c.code = (d <= DEC_LIMIT) ? CHAR_ZERO + CHAR_W'(d)
                                  : CHAR_A + CHAR_W'(d - ALPHA_BASE);
        c.last = (i == digits.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(input logic [CHAR_W-1:0] code, input logic last);
      ascii_char_t exp_c;
      if (pending_chars.size() == 0) begin
        flag($sformatf("unexpected character %h last=%b", code, last));
        return;
      end
      exp_c = pending_chars.pop_front();
      if (code !== exp_c.code)
        flag($sformatf("digit_char expected %h got %h", exp_c.code, code));
      if (last !== exp_c.last)
        flag($sformatf("last expected %b got %b (char %h)", exp_c.last, last, code));
    endfunction

    function void close_out();
      if (pending_chars.size() != 0)
        flag($sformatf("%0d characters never arrived", pending_chars.size()));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [VALUE_W-1:0]  in_value;
  logic                cfg_wr_en;
  logic [RADIX_W-1:0]  cfg_radix;
  logic                out_valid;
  logic [CHAR_W-1:0]   out_digit_char;
  logic                out_last;

  radix_spell_board board;
  longint           cycles;
  bit               gaps_on;

  binary_to_radix_ascii uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_radix      (cfg_radix),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Check every strobed character; the receiver never holds results off,
  // so each strobe is a transfer at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) board.check_char(out_digit_char, out_last);
  end

  // Present one value and hold start until the block takes it. An optional
  // gap drops start first; otherwise start stays high into the next item.
  task automatic transfer_value(input logic [VALUE_W-1:0] v);
    if (gaps_on && $urandom_range(0, 99) < 31) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_value(v);
  endtask

  // Drain all expected characters, then write the radix register.
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    start <= 1'b0;
    @(posedge clk);
    while (board.pending_chars.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_radix <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_radix(r);
  endtask

  // Random value with a random significant width, so every digit count shows up.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] raw;
    int                 w;
    raw = VALUE_W'({$urandom, $urandom});
    w   = $urandom_range(0, VALUE_W);
    if ($urandom_range(0, 3) == 0) w = $urandom_range(0, 8);
    if (w == 0) return '0;
    return raw & ((VALUE_W'(1) << w) - VALUE_W'(1));
  endfunction

  initial begin
    logic [VALUE_W-1:0] all_ones;
    logic [RADIX_W-1:0] phase_radix;
    all_ones = '1;
    board    = new();
    gaps_on  = 1'b1;

    // Drive every input known from time zero and hold reset, then release it.
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_value  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_radix <= '0;
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset radix of ten, zero, single and multi digit values, full width.
    transfer_value('0);
    transfer_value(VALUE_W'(9));
    transfer_value(VALUE_W'(10));
    transfer_value(all_ones);

    // Binary: longest output of 63 characters.
    write_radix(RADIX_MIN);
    transfer_value('0);
    transfer_value(VALUE_W'(1));
    transfer_value(all_ones);

    // Base 36: top letter and first two-character value.
    write_radix(RADIX_MAX);
    transfer_value(VALUE_W'(35));
    transfer_value(VALUE_W'(36));
    transfer_value(all_ones);

    // Radix below range acts as binary.
    write_radix('0);
    transfer_value(VALUE_W'(5));
    write_radix(RADIX_W'(1));
    transfer_value(VALUE_W'(5));
    transfer_value('0);

    // Radix above range acts as base 36.
    write_radix('1);
    transfer_value(VALUE_W'(35));
    transfer_value(all_ones);
    write_radix(RADIX_W'(37));
    transfer_value(VALUE_W'(71));

    // Random phases: extremes of the radix first, then random settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: phase_radix = RADIX_MIN;
        1: phase_radix = RADIX_MAX;
        2: phase_radix = '0;
        3: phase_radix = '1;
        default: begin
          if ($urandom_range(0, 3) == 0) phase_radix = RADIX_W'($urandom_range(0, 63));
          else phase_radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        end
      endcase
      write_radix(phase_radix);
      gaps_on = (p != QUIET_PHASE);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) transfer_value(random_value());
    end

    // Let the last characters come out, then settle.
    start <= 1'b0;
    @(posedge clk);
    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.close_out();
    if (board.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
